>>> hdl/ansi_escape_key_decoder_assert.svh
// assertion macros for the terminal key decoder
// expects clk and rst_n in the scope of each use
`ifndef ANSI_ESCAPE_KEY_DECODER_ASSERT_SVH
`define ANSI_ESCAPE_KEY_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define AKD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define AKD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/akd_pkg.sv
// shared constants and types for the terminal key decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package akd_pkg;

  localparam int ByteW         = 8;
  localparam int ParamDepthDef = 16;

  localparam logic [ByteW-1:0] ChrBs        = 8'h08;
  localparam logic [ByteW-1:0] ChrCr        = 8'h0d;
  localparam logic [ByteW-1:0] ChrEsc       = 8'h1b;
  localparam logic [ByteW-1:0] ChrDel       = 8'h7f;
  localparam logic [ByteW-1:0] ChrCsi       = 8'h5b;  // '['
  localparam logic [ByteW-1:0] ChrTilde     = 8'h7e;
  localparam logic [ByteW-1:0] ParamLo      = 8'h30;
  localparam logic [ByteW-1:0] ParamHi      = 8'h3f;
  localparam logic [ByteW-1:0] InterLo      = 8'h20;
  localparam logic [ByteW-1:0] InterHi      = 8'h2f;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [ByteW-1:0] {
    KEY_BACK   = 8'd0,
    KEY_RETURN = 8'd1,
    KEY_DELETE = 8'd2,
    KEY_ESCAPE = 8'd3,
    KEY_UP     = 8'd4,
    KEY_DOWN   = 8'd5,
    KEY_RIGHT  = 8'd6,
    KEY_LEFT   = 8'd7,
    KEY_HOME   = 8'd8,
    KEY_END    = 8'd9,
    KEY_PGUP   = 8'd10,
    KEY_PGDN   = 8'd11
  } key_code_t;

endpackage

`default_nettype wire

>>> hdl/akd_if.sv
// valid/ready channels for the terminal key decoder: received bytes in, key events out
// depends on akd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface akd_in_if import akd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface akd_out_if import akd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  is_named_key;
  byte_t key_value;

  modport source (output valid, output is_named_key, output key_value, input ready);
  modport sink   (input valid, input is_named_key, input key_value, output ready);
endinterface

`default_nettype wire

>>> hdl/ansi_escape_key_decoder.sv
// terminal key decoder: escape sequence parser with a registered key word output
// output: a key word is valid on the cycle after its last byte is accepted
// throughput: one byte per cycle unless the held word stalls; output refills as it drains
// reset (synchronous, rst_n low): parser to ground, parameter count and lead byte cleared,
// output register emptied
// depends on akd_pkg, akd_if and ansi_escape_key_decoder_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "ansi_escape_key_decoder_assert.svh"

module ansi_escape_key_decoder import akd_pkg::*; #(
  parameter int PARAM_DEPTH = ParamDepthDef
) (
  input  wire        clk,
  input  wire        rst_n,
  akd_in_if.sink     in_chan,
  akd_out_if.source  out_chan
);

  localparam int LenW = $clog2(PARAM_DEPTH);
  localparam logic [LenW-1:0] LenMax = LenW'(PARAM_DEPTH - 1);
  localparam logic [LenW-1:0] LenOne = LenW'(1);

  typedef enum logic [2:0] {
    MODE_GROUND,
    MODE_ESC,
    MODE_SWALLOW,
    MODE_PARAM,
    MODE_INTER
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  byte_t            lead_r, lead_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_named_r, out_named_nxt;
  byte_t            out_value_r, out_value_nxt;

  logic   in_acc;
  byte_t  b;
  logic   is_param, is_inter;
  logic   fin_hit;
  byte_t  fin_code;
  logic   emit;
  logic   emit_named;
  byte_t  emit_value;

  assign b        = in_chan.in_byte;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign is_param = (b >= ParamLo) && (b <= ParamHi);
  assign is_inter = (b >= InterLo) && (b <= InterHi);

  // final byte decode of a control sequence
  always_comb begin
    fin_hit  = 1'b1;
    fin_code = KEY_UP;
    case (b)
      8'h41: fin_code = KEY_UP;
      8'h42: fin_code = KEY_DOWN;
      8'h43: fin_code = KEY_RIGHT;
      8'h44: fin_code = KEY_LEFT;
      ChrTilde: begin
        fin_hit = (len_r == LenOne);
        case (lead_r)
          8'h31:   fin_code = KEY_HOME;
          8'h34:   fin_code = KEY_END;
          8'h35:   fin_code = KEY_PGUP;
          8'h36:   fin_code = KEY_PGDN;
          default: fin_hit  = 1'b0;
        endcase
      end
      default: fin_hit = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    lead_nxt   = lead_r;
    emit       = 1'b0;
    emit_named = 1'b1;
    emit_value = b;
    case (mode_r)
      MODE_GROUND: begin
        case (b)
          ChrBs:   begin emit = 1'b1; emit_value = KEY_BACK;   end
          ChrCr:   begin emit = 1'b1; emit_value = KEY_RETURN; end
          ChrDel:  begin emit = 1'b1; emit_value = KEY_DELETE; end
          ChrEsc:  mode_nxt = MODE_ESC;
          default: begin emit = 1'b1; emit_named = 1'b0; end
        endcase
      end
      MODE_ESC: begin
        if (b == ChrEsc) begin
          mode_nxt   = MODE_GROUND;
          emit       = 1'b1;
          emit_value = KEY_ESCAPE;
        end else if (b == ChrCsi) begin
          mode_nxt = MODE_PARAM;
          len_nxt  = '0;
          lead_nxt = '0;
        end else if (b inside {8'h4e, 8'h4f, 8'h50, 8'h5c, 8'h5d, 8'h58, 8'h5e, 8'h5f}) begin
          // one-byte introducers: the next byte is dropped
          mode_nxt = MODE_SWALLOW;
        end else begin
          mode_nxt = MODE_GROUND;
        end
      end
      MODE_SWALLOW: mode_nxt = MODE_GROUND;
      MODE_PARAM: begin
        if (is_param) begin
          if (len_r < LenMax) begin
            if (len_r == '0) lead_nxt = b;
            len_nxt = len_r + LenOne;
          end
        end else if (is_inter) begin
          mode_nxt = MODE_INTER;
        end else begin
          mode_nxt   = MODE_GROUND;
          emit       = fin_hit;
          emit_value = fin_code;
        end
      end
      MODE_INTER: begin
        if (!is_inter) begin
          mode_nxt   = MODE_GROUND;
          emit       = fin_hit;
          emit_value = fin_code;
        end
      end
      default: mode_nxt = MODE_GROUND;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_named_nxt = out_named_r;
    out_value_nxt = out_value_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
      out_named_nxt = emit_named;
      out_value_nxt = emit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GROUND;
      len_r       <= '0;
      lead_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        len_r  <= len_nxt;
        lead_r <= lead_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_named_r <= out_named_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_named_key = out_named_r;
  assign out_chan.key_value    = out_value_r;

  `AKD_ASSERT_IMP(a_len_bound, 1'b1, len_r <= LenMax, "parameter count past its limit")
  `AKD_ASSERT_IMP(a_lead_empty, len_r == '0, lead_r == '0, "lead byte set with no parameter")
  `AKD_ASSERT_NXT(a_ground_emits, in_acc && mode_r == MODE_GROUND && b != ChrEsc,
                  out_valid_r, "ground byte produced no word")
  `AKD_ASSERT_NXT(a_swallow_ret, in_acc && mode_r == MODE_SWALLOW, mode_r == MODE_GROUND,
                  "swallow did not return to ground")
  `AKD_ASSERT_IMP(a_key_range, out_valid_r && out_named_r, out_value_r <= KEY_PGDN,
                  "named key code out of range")

endmodule

`default_nettype wire
